FILE: hdl/skf_pkg.sv
// Shared types, register and sequencer codes, and Q16.16 saturation helpers
// for the scalar Kalman filter step. No dependencies.
package skf_pkg;

	typedef struct packed {
		logic [31:0] val;
		logic        ovf;
	} sat_t;

	typedef struct packed {
		logic [30:0] val;
		logic        ovf;
	} var_t;

	localparam logic signed [31:0] FX_ONE   = 32'sd65536;
	localparam int unsigned        DIV_BITS = 48;

	// Configuration register indexes (byte address / 4)
	localparam logic [2:0] REG_PLANT   = 3'd0;
	localparam logic [2:0] REG_NOISE   = 3'd1;
	localparam logic [2:0] REG_CONTROL = 3'd2;
	localparam logic [2:0] REG_OBSERVE = 3'd3;
	localparam logic [2:0] REG_PROCVAR = 3'd4;
	localparam logic [2:0] REG_MEASVAR = 3'd5;

	// Multiply steps of the sequencer, in issue order
	localparam logic [3:0] STEP_AX  = 4'd0;   // A * x
	localparam logic [3:0] STEP_BU  = 4'd1;   // Bu * u, then xm
	localparam logic [3:0] STEP_AA  = 4'd2;   // A * A
	localparam logic [3:0] STEP_AAP = 4'd3;   // AA * P
	localparam logic [3:0] STEP_QB  = 4'd4;   // Q * B
	localparam logic [3:0] STEP_QBB = 4'd5;   // QB * B, then Pm
	localparam logic [3:0] STEP_NUM = 4'd6;   // Pm * C
	localparam logic [3:0] STEP_CC  = 4'd7;   // C * C
	localparam logic [3:0] STEP_CCP = 4'd8;   // CC * Pm, then denominator
	localparam logic [3:0] STEP_CXM = 4'd9;   // C * xm, then innovation
	localparam logic [3:0] STEP_GI  = 4'd10;  // g * innovation, then estimate
	localparam logic [3:0] STEP_GC  = 4'd11;  // g * C, then 1 - gC
	localparam logic [3:0] STEP_TP  = 4'd12;  // (1 - gC) * Pm, then new variance

	// Q16.16 product: floor shift by 16, saturate to signed 32 bits
	function automatic sat_t fx_round(input logic signed [63:0] p);
		sat_t r;
		if (p[63:47] == '0 || p[63:47] == '1) begin
			r.val = p[47:16];
			r.ovf = 1'b0;
		end else begin
			r.val = p[63] ? 32'h8000_0000 : 32'h7fff_ffff;
			r.ovf = 1'b1;
		end
		return r;
	endfunction

	function automatic sat_t sat33(input logic signed [32:0] v);
		sat_t r;
		if (v[32] == v[31]) begin
			r.val = v[31:0];
			r.ovf = 1'b0;
		end else begin
			r.val = v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
			r.ovf = 1'b1;
		end
		return r;
	endfunction

	// Clamp to the variance range 0 .. 2^31-1
	function automatic var_t clamp33(input logic signed [32:0] v);
		var_t r;
		if (v[32]) begin
			r.val = '0;
			r.ovf = 1'b1;
		end else if (v[31]) begin
			r.val = '1;
			r.ovf = 1'b1;
		end else begin
			r.val = v[30:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

endpackage

FILE: hdl/scalar_kalman_filter_step.sv
// One-dimensional Kalman filter step, signed Q16.16, top level.
// Depends on skf_pkg for saturation helpers and sequencer codes.
//
// Each accepted word (measurement, control_value) runs predict, gain and
// update through one shared 32x32 multiplier and a one-bit-per-cycle
// restoring divider, and yields one result word. Each of the 13 products is
// multiplied (ST_MUL), then rounded, saturated and accumulated (ST_POST);
// the gain division sets up, produces 48 quotient bits and fixes the sign,
// and the result is then loaded into the output register.
// in_stall stays high until the result is loaded; the next word is taken the
// cycle after the result is loaded, even while it still waits on out_stall.
// A zero denominator skips the division (gain 0). Configuration is a small
// APB port, registers at byte addresses 0,4,..,20; write only while idle.
module scalar_kalman_filter_step
	import skf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// APB configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] measurement,
	input  logic signed [31:0] control_value,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] estimate,
	output logic [30:0]        error_variance,
	output logic signed [31:0] kalman_gain,
	output logic               overflow
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_POST = 7'b0000100,
		ST_DSET = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_DEND = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration
	logic signed [31:0] plant_q, noise_q, control_q, observe_q;
	logic [30:0]        procvar_q, measvar_q;

	// filter state
	logic signed [31:0] x_q;
	logic [30:0]        p_q;

	// working registers
	logic signed [31:0] y_q, u_q;
	logic signed [31:0] r_a_q, r_b_q, xm_q, num_q, g_q;
	logic [30:0]        pm_q, den_q;
	logic [3:0]         step_q;
	logic               ovf_q;
	logic signed [63:0] prod_q;

	// divider
	logic [30:0]        rem_q;
	logic [47:0]        quo_q;
	logic [5:0]         div_cnt_q;
	logic               neg_q;

	// output register
	logic               out_valid_q;
	logic signed [31:0] est_out_q, gain_out_q;
	logic [30:0]        var_out_q;
	logic               ovf_out_q;

	logic               cfg_wr;
	logic [2:0]         cfg_idx;
	logic signed [31:0] op_a, op_b;
	sat_t               fx;
	logic signed [32:0] add_a, add_b, sum;
	sat_t               s33;
	var_t               c33, cfx;
	logic [31:0]        div_sh;
	logic [32:0]        div_diff;
	logic [31:0]        num_mag;
	logic               quo_big_pos, quo_big_neg;
	logic               out_free;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign cfg_idx  = paddr[4:2];
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign estimate       = est_out_q;
	assign error_variance = var_out_q;
	assign kalman_gain    = gain_out_q;
	assign overflow       = ovf_out_q;

	always_comb begin
		case (cfg_idx)
			REG_PLANT:   prdata = plant_q;
			REG_NOISE:   prdata = noise_q;
			REG_CONTROL: prdata = control_q;
			REG_OBSERVE: prdata = observe_q;
			REG_PROCVAR: prdata = {1'b0, procvar_q};
			REG_MEASVAR: prdata = {1'b0, measvar_q};
			default:     prdata = '0;
		endcase
	end

	// multiplier operand select
	always_comb begin
		case (step_q)
			STEP_AX:  begin op_a = plant_q;              op_b = x_q;                 end
			STEP_BU:  begin op_a = control_q;            op_b = u_q;                 end
			STEP_AA:  begin op_a = plant_q;              op_b = plant_q;             end
			STEP_AAP: begin op_a = r_a_q;                op_b = $signed({1'b0, p_q}); end
			STEP_QB:  begin op_a = $signed({1'b0, procvar_q}); op_b = noise_q;       end
			STEP_QBB: begin op_a = r_a_q;                op_b = noise_q;             end
			STEP_NUM: begin op_a = $signed({1'b0, pm_q}); op_b = observe_q;          end
			STEP_CC:  begin op_a = observe_q;            op_b = observe_q;           end
			STEP_CCP: begin op_a = r_a_q;                op_b = $signed({1'b0, pm_q}); end
			STEP_CXM: begin op_a = observe_q;            op_b = xm_q;                end
			STEP_GI:  begin op_a = g_q;                  op_b = r_a_q;               end
			STEP_GC:  begin op_a = g_q;                  op_b = observe_q;           end
			STEP_TP:  begin op_a = r_a_q;                op_b = $signed({1'b0, pm_q}); end
			default:  begin op_a = '0;                   op_b = '0;                  end
		endcase
	end

	assign fx = fx_round(prod_q);

	// post-multiply accumulate operands
	always_comb begin
		add_a = '0;
		add_b = 33'(signed'(fx.val));
		case (step_q)
			STEP_BU:  add_a = 33'(r_a_q);
			STEP_QBB: add_a = 33'(r_b_q);
			STEP_CCP: add_a = $signed({2'b00, measvar_q});
			STEP_CXM: begin
				add_a = 33'(y_q);
				add_b = -33'(signed'(fx.val));
			end
			STEP_GI:  add_a = 33'(xm_q);
			STEP_GC: begin
				add_a = 33'(FX_ONE);
				add_b = -33'(signed'(fx.val));
			end
			default:  add_a = '0;
		endcase
	end

	assign sum = add_a + add_b;
	assign s33 = sat33(sum);
	assign c33 = clamp33(sum);
	assign cfx = clamp33(33'(signed'(fx.val)));

	// restoring divider step
	assign div_sh   = {rem_q, quo_q[47]};
	assign div_diff = {1'b0, div_sh} - {2'b00, den_q};
	assign num_mag  = num_q[31] ? 32'(-num_q) : 32'(num_q);

	assign quo_big_pos = (quo_q[47:31] != '0);
	assign quo_big_neg = (quo_q[47:32] != '0) || (quo_q[31] && (quo_q[30:0] != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plant_q   <= FX_ONE;
			noise_q   <= FX_ONE;
			control_q <= FX_ONE;
			observe_q <= FX_ONE;
			procvar_q <= 31'd655;
			measvar_q <= 31'd131072;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_PLANT:   plant_q   <= pwdata;
				REG_NOISE:   noise_q   <= pwdata;
				REG_CONTROL: control_q <= pwdata;
				REG_OBSERVE: observe_q <= pwdata;
				REG_PROCVAR: procvar_q <= pwdata[30:0];
				REG_MEASVAR: measvar_q <= pwdata[30:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_AX;
			x_q         <= '0;
			p_q         <= '0;
			ovf_q       <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a finished word, else drop the taken one
			if (state_q == ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						y_q     <= measurement;
						u_q     <= control_value;
						step_q  <= STEP_AX;
						ovf_q   <= 1'b0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= 64'(op_a) * 64'(op_b);
					state_q <= ST_POST;
				end
				ST_POST: begin
					step_q  <= step_q + 4'd1;
					case (step_q)
						STEP_AX, STEP_AA, STEP_QB, STEP_CC: begin
							r_a_q   <= fx.val;
							ovf_q   <= ovf_q | fx.ovf;
							state_q <= ST_MUL;
						end
						STEP_AAP: begin
							r_b_q   <= fx.val;
							ovf_q   <= ovf_q | fx.ovf;
							state_q <= ST_MUL;
						end
						STEP_NUM: begin
							num_q   <= fx.val;
							ovf_q   <= ovf_q | fx.ovf;
							state_q <= ST_MUL;
						end
						STEP_BU: begin
							xm_q    <= s33.val;
							ovf_q   <= ovf_q | fx.ovf | s33.ovf;
							state_q <= ST_MUL;
						end
						STEP_QBB: begin
							pm_q    <= c33.val;
							ovf_q   <= ovf_q | fx.ovf | c33.ovf;
							state_q <= ST_MUL;
						end
						STEP_CCP: begin
							den_q   <= c33.val;
							ovf_q   <= ovf_q | fx.ovf | c33.ovf;
							state_q <= ST_DSET;
						end
						STEP_CXM, STEP_GC: begin
							r_a_q   <= s33.val;
							ovf_q   <= ovf_q | fx.ovf | s33.ovf;
							state_q <= ST_MUL;
						end
						STEP_GI: begin
							x_q     <= s33.val;
							ovf_q   <= ovf_q | fx.ovf | s33.ovf;
							state_q <= ST_MUL;
						end
						STEP_TP: begin
							p_q     <= cfx.val;
							ovf_q   <= ovf_q | fx.ovf | cfx.ovf;
							state_q <= ST_FIN;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_DSET: begin
					if (den_q == '0) begin
						// no division: gain is zero, no overflow
						g_q     <= '0;
						step_q  <= STEP_CXM;
						state_q <= ST_MUL;
					end else begin
						rem_q     <= '0;
						quo_q     <= {num_mag, 16'h0000};
						neg_q     <= num_q[31];
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!div_diff[32]) begin
						rem_q <= div_diff[30:0];
						quo_q <= {quo_q[46:0], 1'b1};
					end else begin
						rem_q <= div_sh[30:0];
						quo_q <= {quo_q[46:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'(DIV_BITS - 1))
						state_q <= ST_DEND;
				end
				ST_DEND: begin
					// apply sign, saturate to signed 32 bits
					if (neg_q) begin
						g_q   <= quo_big_neg ? 32'sh8000_0000 : -$signed(quo_q[31:0]);
						ovf_q <= ovf_q | quo_big_neg;
					end else begin
						g_q   <= quo_big_pos ? 32'sh7fff_ffff : $signed(quo_q[31:0]);
						ovf_q <= ovf_q | quo_big_pos;
					end
					step_q  <= STEP_CXM;
					state_q <= ST_MUL;
				end
				ST_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						est_out_q   <= x_q;
						var_out_q   <= p_q;
						gain_out_q  <= g_q;
						ovf_out_q   <= ovf_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_MUL && step_q == STEP_AX))
		else $error("accepted word did not start the multiply sequence");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && out_stall) |=> (state_q == ST_FIN))
		else $error("result loaded over a stalled output word");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_cnt_q < 6'(DIV_BITS)))
		else $error("divider ran past its bit count");
`endif

endmodule
